// File: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and constants of the Go-Back-N sender window core.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Field and register widths
    localparam int OP_W       = 2;
    localparam int ACK_W      = 16;
    localparam int WIN_W      = 6;
    localparam int TOTAL_W    = 16;
    localparam int TMO_W      = 20;
    localparam int SQ_W       = 17;   // internal sequence arithmetic
    localparam int SEQ_W      = 16;   // sequence number as transmitted
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int ALU_W      = 20;

    // Sequence numbers are reported modulo 2**SEQ_BITS
    localparam int SEQ_BITS = 16;
    localparam logic [SEQ_W-1:0] SEQ_MASK = (SEQ_BITS >= SEQ_W) ? {SEQ_W{1'b1}} :
        SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);

    localparam int DEF_MAX_WINDOW = 32;

    // Register reset values
    localparam logic [WIN_W-1:0]   WINDOW_RST  = 6'd32;
    localparam logic [TOTAL_W-1:0] TOTAL_RST   = 16'd0;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST = 20'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ACK   = 2'd1,
        OP_START = 2'd2
    } op_t;

    // The one operation code with no meaning; the core ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW  = 2'd0,
        KIND_RETX = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW  = 2'd0,
        REG_TOTAL   = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_DONE,
        ST_LIM,
        ST_END,
        ST_CNT,
        ST_TINC,
        ST_TCMP,
        ST_SEND,
        ST_RETX,
        ST_ACK_LO,
        ST_ACK_HI,
        ST_ACK_UPD
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             ge;     // a >= b, valid for subtraction
        logic             zero;
    } alu_rsp_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } emit_t;

    function automatic logic [SEQ_W-1:0] seq_field(input logic [SQ_W-1:0] v);
        logic [SQ_W-1:0] m;
        m = v & SEQ_MASK;
        return m[SEQ_W-1:0];
    endfunction

endpackage

// File: rtl/go_back_n_sender_window_core.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// Go-Back-N sender window control with a sequenced shared ALU.
// ----------------------------------------------------------------------------
// Usage: each input transaction on the s_ group is a tick, an acknowledgement
// or a start. A start resets the window (base and next sequence to one, timer
// stopped, done cleared) in the idle state. A flagged acknowledgement is
// checked against the outstanding range in ST_ACK_LO and ST_ACK_HI and
// moves the base in ST_ACK_UPD if in range, with no output; one with the
// flag clear, or one after done, is dropped. A tick checks the base against
// the packet count in ST_CHK, then works the window and timer on the shared
// ALU in ST_LIM, ST_END, ST_CNT, ST_TINC and ST_TCMP; results follow one per
// cycle on the m_ group while the receiver does not stall: new sequence
// numbers first, then, on a timeout, every outstanding number again. The
// last result of a tick carries tlast. Once the base passes the packet count
// a tick reports done once; later ticks give nothing until the next start.
// s_tready is high only while the sequencer is idle, so one item is in work
// at a time. A single output register sits between the sequencer and the m_
// group; if the receiver stalls, the sequencer waits with the next result
// and resumes as soon as the register is taken, so nothing is lost. The
// configuration channel is always ready and should be written only while
// idle. Reset clears the window state and loads the register defaults
// (window 32, no packets, timeout 1000 ticks).
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core
#(
    parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,     // [15:0] ack_number
    input  logic [2:0]                     s_tuser,     // [1:0] operation, [2] ack_valid
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,     // [15:0] seq_number
    output logic [1:0]                     m_tuser,     // [1:0] kind
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gbn_pkg::*;

    logic [WIN_W-1:0]   window_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TMO_W-1:0]   timeout_reg;

    logic             m_valid_reg;
    logic [SEQ_W-1:0] m_data_reg;
    kind_t            m_kind_reg;
    logic             m_last_reg;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    emit_t    emit;
    logic     emit_ready;

    // Configuration registers; an index beyond the list is accepted and dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RST;
            total_reg   <= TOTAL_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW:  window_reg  <= cfg_data[WIN_W-1:0];
                REG_TOTAL:   total_reg   <= cfg_data[TOTAL_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TMO_W-1:0];
                default:     window_reg  <= window_reg;
            endcase
        end
    end

    gbn_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    gbn_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser[1:0]),
        .in_ack        (s_tdata),
        .in_ack_ok     (s_tuser[2]),
        .window_size   (window_reg),
        .total_packets (total_reg),
        .timeout_ticks (timeout_reg),
        .alu_req       (alu_req),
        .alu_rsp       (alu_rsp),
        .emit          (emit),
        .emit_ready    (emit_ready)
    );

    // Output register: a new result may load in the same cycle that the
    // previous one is taken by the receiver.
    assign emit_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit_ready)
            m_valid_reg <= emit.valid;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid && emit_ready)
        begin
            m_data_reg <= emit.seq;
            m_kind_reg <= emit.kind;
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/gbn_alu.sv
// ----------------------------------------------------------------------------
// gbn_alu
// Shared adder and magnitude comparator used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module gbn_alu
(
    input  gbn_pkg::alu_req_t req,
    output gbn_pkg::alu_rsp_t rsp
);
    import gbn_pkg::*;

    logic [ALU_W:0]   full;
    logic [ALU_W-1:0] b_op;

    // Subtraction is a + ~b + 1; the carry out is then set exactly when a >= b.
    assign b_op = req.sub ? ~req.b : req.b;
    assign full = {1'b0, req.a} + {1'b0, b_op} + (ALU_W + 1)'(req.sub);

    assign rsp.sum  = full[ALU_W-1:0];
    assign rsp.ge   = full[ALU_W];
    assign rsp.zero = (full[ALU_W-1:0] == '0);

endmodule

// File: rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window state and step sequencer; drives the shared ALU one operation a cycle.
// ----------------------------------------------------------------------------
module gbn_ctrl
#(
    parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gbn_pkg::OP_W-1:0]    in_op,
    input  logic [gbn_pkg::ACK_W-1:0]   in_ack,
    input  logic                        in_ack_ok,
    input  logic [gbn_pkg::WIN_W-1:0]   window_size,
    input  logic [gbn_pkg::TOTAL_W-1:0] total_packets,
    input  logic [gbn_pkg::TMO_W-1:0]   timeout_ticks,
    output gbn_pkg::alu_req_t           alu_req,
    input  gbn_pkg::alu_rsp_t           alu_rsp,
    output gbn_pkg::emit_t              emit,
    input  logic                        emit_ready
);
    import gbn_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam logic [WIN_W-1:0] MAXW = WIN_W'(MAX_WINDOW);

    state_t           state_reg, state_next;
    logic [SQ_W-1:0]  base_reg, base_next;
    logic [SQ_W-1:0]  nseq_reg, nseq_next;
    logic             run_reg, run_next;
    logic [TMO_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic [SQ_W-1:0]  acc_reg, acc_next;      // window limit, then send end
    logic [ACK_W-1:0] ack_reg, ack_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;      // new packets still to send
    logic             tmo_reg, tmo_next;      // retransmission due this tick
    logic [SQ_W-1:0]  s_reg, s_next;          // retransmission pointer
    logic [TMO_W-1:0] tcnt_reg, tcnt_next;    // advanced timer value

    logic [WIN_W-1:0] win_eff;
    logic             same;
    logic             run_after;

    assign win_eff = (window_size == '0) ? WIN_W'(1) :
                     (window_size > MAXW) ? MAXW : window_size;
    assign same      = (base_reg == nseq_reg);
    assign run_after = run_reg | same;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= SQ_W'(1);
            nseq_reg  <= SQ_W'(1);
            run_reg   <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            tmo_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            nseq_reg  <= nseq_next;
            run_reg   <= run_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            tmo_reg   <= tmo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        ack_reg  <= ack_next;
        s_reg    <= s_next;
        tcnt_reg <= tcnt_next;
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        nseq_next  = nseq_reg;
        run_next   = run_reg;
        count_next = count_reg;
        done_next  = done_reg;
        acc_next   = acc_reg;
        ack_next   = ack_reg;
        cnt_next   = cnt_reg;
        tmo_next   = tmo_reg;
        s_next     = s_reg;
        tcnt_next  = tcnt_reg;
        in_ready   = 1'b0;
        alu_req    = '0;
        emit       = '0;
        emit.kind  = KIND_NEW;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        OP_START:
                        begin
                            base_next  = SQ_W'(1);
                            nseq_next  = SQ_W'(1);
                            run_next   = 1'b0;
                            count_next = '0;
                            done_next  = 1'b0;
                        end
                        OP_ACK:
                        begin
                            ack_next = in_ack;
                            if (in_ack_ok && !done_reg)
                                state_next = ST_ACK_LO;
                        end
                        OP_TICK:
                        begin
                            if (!done_reg)
                                state_next = ST_CHK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ACK_LO:
            begin
                alu_req.a   = ALU_W'(ack_reg);
                alu_req.b   = ALU_W'(base_reg);
                alu_req.sub = 1'b1;
                state_next  = alu_rsp.ge ? ST_ACK_HI : ST_IDLE;
            end

            ST_ACK_HI:
            begin
                alu_req.a   = ALU_W'(nseq_reg);
                alu_req.b   = ALU_W'(ack_reg);
                alu_req.sub = 1'b1;
                state_next  = (alu_rsp.ge && !alu_rsp.zero) ? ST_ACK_UPD : ST_IDLE;
            end

            ST_ACK_UPD:
            begin
                alu_req.a  = ALU_W'(ack_reg);
                alu_req.b  = ALU_W'(1);
                base_next  = alu_rsp.sum[SQ_W-1:0];
                if (alu_rsp.sum[SQ_W-1:0] == nseq_reg)
                begin
                    run_next = 1'b0;
                end
                else
                begin
                    run_next   = 1'b1;
                    count_next = '0;
                end
                state_next = ST_IDLE;
            end

            ST_CHK:
            begin
                alu_req.a   = ALU_W'(total_packets);
                alu_req.b   = ALU_W'(base_reg);
                alu_req.sub = 1'b1;
                state_next  = alu_rsp.ge ? ST_LIM : ST_DONE;
            end

            ST_DONE:
            begin
                emit.valid = 1'b1;
                emit.kind  = KIND_DONE;
                emit.seq   = '0;
                emit.last  = 1'b1;
                if (emit_ready)
                begin
                    done_next  = 1'b1;
                    run_next   = 1'b0;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_LIM:
            begin
                alu_req.a  = ALU_W'(base_reg);
                alu_req.b  = ALU_W'(win_eff);
                acc_next   = alu_rsp.sum[SQ_W-1:0];
                state_next = ST_END;
            end

            ST_END:
            begin
                // Sending stops at the window limit or after the last packet.
                alu_req.a   = ALU_W'(total_packets);
                alu_req.b   = ALU_W'(acc_reg);
                alu_req.sub = 1'b1;
                if (!alu_rsp.ge)
                    acc_next = {1'b0, total_packets} + SQ_W'(1);
                state_next = ST_CNT;
            end

            ST_CNT:
            begin
                alu_req.a   = ALU_W'(acc_reg);
                alu_req.b   = ALU_W'(nseq_reg);
                alu_req.sub = 1'b1;
                cnt_next    = (alu_rsp.ge && !alu_rsp.zero) ? alu_rsp.sum[CNT_W-1:0] : '0;
                state_next  = ST_TINC;
            end

            ST_TINC:
            begin
                // With nothing outstanding the first send restarts the timer.
                alu_req.a  = same ? '0 : ALU_W'(count_reg);
                alu_req.b  = ALU_W'(1);
                tcnt_next  = alu_rsp.sum[TMO_W-1:0];
                state_next = ST_TCMP;
            end

            ST_TCMP:
            begin
                alu_req.a   = ALU_W'(tcnt_reg);
                alu_req.b   = ALU_W'(timeout_ticks);
                alu_req.sub = 1'b1;
                tmo_next    = 1'b0;
                if (run_after)
                begin
                    run_next   = 1'b1;
                    count_next = alu_rsp.ge ? '0 : tcnt_reg;
                    tmo_next   = alu_rsp.ge && (!same || (cnt_reg != '0));
                end
                s_next = base_reg;
                if (cnt_reg != '0)
                    state_next = ST_SEND;
                else if (run_after && alu_rsp.ge && !same)
                    state_next = ST_RETX;
                else
                    state_next = ST_IDLE;
            end

            ST_SEND:
            begin
                emit.valid = 1'b1;
                emit.kind  = KIND_NEW;
                emit.seq   = seq_field(nseq_reg);
                emit.last  = (cnt_reg == CNT_W'(1)) && !tmo_reg;
                if (emit_ready)
                begin
                    nseq_next = nseq_reg + SQ_W'(1);
                    cnt_next  = cnt_reg - CNT_W'(1);
                    s_next    = base_reg;
                    if (cnt_reg == CNT_W'(1))
                        state_next = tmo_reg ? ST_RETX : ST_IDLE;
                end
            end

            ST_RETX:
            begin
                emit.valid = 1'b1;
                emit.kind  = KIND_RETX;
                emit.seq   = seq_field(s_reg);
                emit.last  = ((s_reg + SQ_W'(1)) == nseq_reg);
                if (emit_ready)
                begin
                    s_next = s_reg + SQ_W'(1);
                    if ((s_reg + SQ_W'(1)) == nseq_reg)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the sender window core, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    import gbn_pkg::*;

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result changed while stalled");

    // The done report stands alone and carries sequence number zero.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DONE) |-> m_tlast && (m_tdata == '0))
        else $error("malformed done report");

    // A start or an unused operation completes in the cycle it is taken.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tuser[1:0] == OP_START) || (s_tuser[1:0] == OP_UNUSED))
        |=> s_tready)
        else $error("start did not complete in one cycle");

    // Configuration is never back-pressured.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker (.*);
